/* hdl/mobt_pkg.sv */
// Package: shared types and codes for the multicart outer bank translator.
`timescale 1ns / 1ps
package mobt_pkg;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_PRG   = 2'd1;
	localparam logic [1:0] ACT_CHR   = 2'd2;

	localparam logic [3:0] WIN_LO_PAGE = 4'h6;
	localparam logic [3:0] WIN_HI_PAGE = 4'h5;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] address;
		logic [7:0]  data_value;
		logic [7:0]  inner_mode_bits;
		logic [7:0]  inner_chr_bank0;
		logic [7:0]  inner_chr_bank1;
	} in_item_t;

	typedef struct packed {
		logic [11:0] final_bank;
		logic [2:0]  window_slot;
		logic        write_taken;
	} out_item_t;

	typedef logic [3:0][7:0] outer_regs_t;

endpackage

/* hdl/mobt_regs.sv */
// Outer bank register file with CPU write window decode and lock.
`timescale 1ns / 1ps
module mobt_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [15:0]           wr_addr,
	input  logic [7:0]            wr_data,
	input  logic                  window_select,
	output logic                  wr_taken,
	output mobt_pkg::outer_regs_t regs
);

	mobt_pkg::outer_regs_t regs_q;
	logic                  hit;
	logic                  locked;

	assign hit      = wr_addr[15:12] ==
		(window_select ? mobt_pkg::WIN_HI_PAGE : mobt_pkg::WIN_LO_PAGE);
	assign locked   = regs_q[3][7] && !regs_q[3][4];
	assign wr_taken = wr_en && hit && !locked;
	assign regs     = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (wr_taken) begin
			regs_q[wr_addr[1:0]] <= wr_data;
		end
	end

`ifndef SYNTHESIS
	a_locked_hold: assert property (@(posedge clk) disable iff (!arst_n)
		locked |=> $stable(regs_q))
		else $error("outer registers changed while locked");
`endif

endmodule

/* hdl/mobt_xlate.sv */
// Bank translation logic: PRG and CHR mapping through the outer registers.
`timescale 1ns / 1ps
module mobt_xlate #(
	parameter int PRG_BANK_COUNT = 512,
	parameter int CHR_BANK_COUNT = 256
) (
	input  mobt_pkg::in_item_t    item,
	input  mobt_pkg::outer_regs_t regs,
	input  logic                  wr_taken,
	output mobt_pkg::out_item_t   result
);

	localparam logic [11:0] PRG_WRAP = 12'(PRG_BANK_COUNT - 1);
	localparam logic [11:0] CHR_WRAP = 12'(CHR_BANK_COUNT - 1);

	logic [7:0]  r0, r1, r2, r3;
	logic [7:0]  prg_mask;
	logic [7:0]  prg_base;
	logic [7:0]  prg_v;
	logic [3:0]  prg_emask;
	logic [11:0] prg_out;
	logic [7:0]  chr_mask;
	logic [7:0]  chr_hi;
	logic [15:0] chr_key;
	logic [7:0]  chr_v;
	logic [7:0]  chr_out;

	assign r0 = regs[0];
	assign r1 = regs[1];
	assign r2 = regs[2];
	assign r3 = regs[3];

	always_comb begin
		prg_mask = {r1[5], r1[6], ~r1[7], ~r0[6], 4'hF};
		prg_base = {r0[5:4], r1[3:2], r1[4], r0[2:0]};
		prg_v    = item.data_value;
		if (r3[6] && item.data_value >= 8'hFE && !item.inner_mode_bits[6]
				&& item.address[15:14] == 2'b11) begin
			prg_v = 8'h00;
		end
		if (r1[1]) begin
			prg_emask = {r3[3:2], item.address[14], 1'b0};
		end else begin
			prg_emask = {r3[3:1], 1'b0};
		end
		if (!r3[4]) begin
			prg_out = ({prg_base, 4'h0} & ~{4'h0, prg_mask})
				| {4'h0, prg_v & prg_mask};
		end else begin
			prg_out = ({prg_base, 4'h0} & ~{4'h0, prg_mask & 8'hF0})
				| {4'h0, prg_v & prg_mask & 8'hF0}
				| {8'h00, prg_emask} | {11'h000, item.address[13]};
		end
	end

	always_comb begin
		chr_mask = {~r0[7], 7'h7F};
		chr_hi   = {r0[3] & r0[7], 7'h00};
		chr_key  = item.address ^ {3'b000, item.inner_mode_bits[7], 12'h000};
		chr_v    = item.data_value;
		if (r3[4]) begin
			if (r3[6] && (chr_key == 16'h0400 || chr_key == 16'h0C00)) begin
				chr_v = {1'b0, chr_v[6:0]};
			end
			chr_out = (chr_v & 8'h80 & chr_mask) | chr_hi
				| {1'b0, r2[3:0], item.address[12:10]};
		end else begin
			if (r3[6]) begin
				if (chr_key == 16'h0000) begin
					chr_v = item.inner_chr_bank0;
				end else if (chr_key == 16'h0800) begin
					chr_v = item.inner_chr_bank1;
				end else if (chr_key == 16'h0400 || chr_key == 16'h0C00) begin
					chr_v = 8'h00;
				end
			end
			chr_out = (chr_v & chr_mask) | chr_hi;
		end
	end

	always_comb begin
		result = '0;
		case (item.action)
			mobt_pkg::ACT_WRITE: begin
				result.write_taken = wr_taken;
			end
			mobt_pkg::ACT_PRG: begin
				result.final_bank  = prg_out & PRG_WRAP;
				result.window_slot = {1'b0, item.address[14:13]};
			end
			mobt_pkg::ACT_CHR: begin
				result.final_bank  = {4'h0, chr_out} & CHR_WRAP;
				result.window_slot = item.address[12:10];
			end
			default: begin
				result = '0;
			end
		endcase
	end

endmodule

/* hdl/multicart_outer_bank_translator_unit.sv */
// Top level: input register, outer register bank, translation and result register.
// The input register item is translated and captured in the result register.
// Throughput: one transaction per cycle, limited only by output stall.
// Register writes take effect for the very next transaction.
// Reset (arst_n low, asynchronous): outer registers and window select clear to zero,
// both stages empty.
`timescale 1ns / 1ps
module multicart_outer_bank_translator_unit #(
	parameter int PRG_BANK_COUNT = 512,
	parameter int CHR_BANK_COUNT = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mobt_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output mobt_pkg::out_item_t out_data,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data
);

	localparam logic [11:0] ANY_WRAP =
		12'(PRG_BANK_COUNT - 1) | 12'(CHR_BANK_COUNT - 1);

	logic                  window_select_q;
	logic                  valid_s1;
	mobt_pkg::in_item_t    item_s1;
	logic                  valid_s2;
	mobt_pkg::out_item_t   result_s2;
	logic                  load_s2;
	logic                  adv_s1;
	logic                  wr_taken;
	mobt_pkg::outer_regs_t regs;
	mobt_pkg::out_item_t   result;

	assign load_s2  = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && load_s2;
	assign in_stall = valid_s1 && !load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_select_q <= 1'b0;
		end else if (cfg_wr_en) begin
			window_select_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= adv_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (adv_s1) begin
			result_s2 <= result;
		end
	end

	mobt_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (adv_s1 && item_s1.action == mobt_pkg::ACT_WRITE),
		.wr_addr       (item_s1.address),
		.wr_data       (item_s1.data_value),
		.window_select (window_select_q),
		.wr_taken      (wr_taken),
		.regs          (regs)
	);

	mobt_xlate #(
		.PRG_BANK_COUNT (PRG_BANK_COUNT),
		.CHR_BANK_COUNT (CHR_BANK_COUNT)
	) u_xlate (
		.item     (item_s1),
		.regs     (regs),
		.wr_taken (wr_taken),
		.result   (result)
	);

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

`ifndef SYNTHESIS
	a_write_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.write_taken |->
			result_s2.final_bank == 12'h000 && result_s2.window_slot == 3'd0)
		else $error("write transaction carries bank or slot");
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (result_s2.final_bank & ~ANY_WRAP) == 12'h000)
		else $error("final bank exceeds ROM size");
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && out_stall |-> in_stall)
		else $error("input taken while both stages are blocked");
`endif

endmodule

/* test/tb_multicart_outer_bank_translator_unit.sv */
// Testbench for the outer bank translator: directed and random transactions vs. a predictor.
`timescale 1ns / 1ps
module tb_multicart_outer_bank_translator_unit;

	localparam int PRG_COUNT = 512;
	localparam int CHR_COUNT = 256;
	localparam logic [1:0] ACT_NONE = 2'd3;
	localparam int QUIET_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	mobt_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	mobt_pkg::out_item_t out_data;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;

	mobt_pkg::outer_regs_t bank_regs_m = '0;
	logic win_sel_m = 1'b0;
	mobt_pkg::out_item_t bank_results_q[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int checked_count = 0;
	int taken_count = 0;
	int prg_count = 0;
	int chr_count = 0;
	int quiet_cycles = 0;

	multicart_outer_bank_translator_unit #(
		.PRG_BANK_COUNT(PRG_COUNT),
		.CHR_BANK_COUNT(CHR_COUNT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic logic [11:0] prg_bank_of(logic [15:0] addr, logic [7:0] inner,
			logic [7:0] mode);
		logic [7:0] r0, r1, r3, v;
		logic [11:0] msk, base, res;
		logic [3:0] low_bits;
		r0 = bank_regs_m[0];
		r1 = bank_regs_m[1];
		r3 = bank_regs_m[3];
		msk = {4'h0, ((8'h3F | (r1 & 8'h40) | {r1[5], 7'h00}) ^ {3'b000, r0[6], 4'h0})
			^ {2'b00, r1[7], 5'h00}};
		base = {4'h0, r0[5:4], r1[3:2], r1[4], r0[2:0]};
		v = inner;
		if (r3[6] && inner >= 8'hFE && !mode[6] && addr[15:14] == 2'b11) begin
			v = 8'h00;
		end
		if (!r3[4]) begin
			res = ((base << 4) & ~msk) | ({4'h0, v} & msk);
		end else begin
			msk = msk & 12'h0F0;
			low_bits = r1[1] ? {r3[3:2], addr[14], 1'b0} : {r3[3:1], 1'b0};
			res = ((base << 4) & ~msk) | ({4'h0, v} & msk) | {8'h00, low_bits}
				| {11'h000, addr[13]};
		end
		return res & 12'(PRG_COUNT - 1);
	endfunction

	function automatic logic [11:0] chr_bank_of(logic [15:0] addr, logic [7:0] inner,
			logic [7:0] mode, logic [7:0] c0, logic [7:0] c1);
		logic [7:0] r0, r2, r3, v, msk, hi, res;
		logic [15:0] key;
		r0 = bank_regs_m[0];
		r2 = bank_regs_m[2];
		r3 = bank_regs_m[3];
		msk = {~r0[7], 7'h7F};
		hi = {r0[7] & r0[3], 7'h00};
		key = addr ^ {3'b000, mode[7], 12'h000};
		v = inner;
		if (r3[4]) begin
			if (r3[6] && (key == 16'h0400 || key == 16'h0C00)) begin
				v[7] = 1'b0;
			end
			res = {v[7] & msk[7], 7'h00} | hi | {1'b0, r2[3:0], 3'b000}
				| {5'h00, addr[12:10]};
		end else begin
			if (r3[6]) begin
				if (key == 16'h0000) begin
					v = c0;
				end else if (key == 16'h0800) begin
					v = c1;
				end else if (key == 16'h0400 || key == 16'h0C00) begin
					v = 8'h00;
				end
			end
			res = (v & msk) | hi;
		end
		return {4'h0, res} & 12'(CHR_COUNT - 1);
	endfunction

	function automatic mobt_pkg::out_item_t translate_item(mobt_pkg::in_item_t it);
		mobt_pkg::out_item_t res;
		logic [3:0] page;
		res = '0;
		case (it.action)
			mobt_pkg::ACT_WRITE: begin
				page = win_sel_m ? mobt_pkg::WIN_HI_PAGE : mobt_pkg::WIN_LO_PAGE;
				if (it.address[15:12] == page
						&& !(bank_regs_m[3][7] && !bank_regs_m[3][4])) begin
					bank_regs_m[it.address[1:0]] = it.data_value;
					res.write_taken = 1'b1;
				end
			end
			mobt_pkg::ACT_PRG: begin
				res.final_bank = prg_bank_of(it.address, it.data_value,
					it.inner_mode_bits);
				res.window_slot = {1'b0, it.address[14:13]};
			end
			mobt_pkg::ACT_CHR: begin
				res.final_bank = chr_bank_of(it.address, it.data_value,
					it.inner_mode_bits, it.inner_chr_bank0, it.inner_chr_bank1);
				res.window_slot = it.address[12:10];
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	function automatic mobt_pkg::in_item_t mk_item(logic [1:0] act, logic [15:0] addr,
			logic [7:0] data, logic [7:0] mode = 8'h00, logic [7:0] c0 = 8'h00,
			logic [7:0] c1 = 8'h00);
		mobt_pkg::in_item_t it;
		it.action = act;
		it.address = addr;
		it.data_value = data;
		it.inner_mode_bits = mode;
		it.inner_chr_bank0 = c0;
		it.inner_chr_bank1 = c1;
		return it;
	endfunction

	function automatic mobt_pkg::in_item_t random_item(bit allow_lock);
		mobt_pkg::in_item_t it;
		int pick;
		it.address = 16'($urandom);
		it.data_value = 8'($urandom);
		it.inner_mode_bits = 8'($urandom);
		it.inner_chr_bank0 = 8'($urandom);
		it.inner_chr_bank1 = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 30) begin
			it.action = mobt_pkg::ACT_WRITE;
			if ($urandom_range(9) < 8) begin
				it.address[15:12] = win_sel_m ? mobt_pkg::WIN_HI_PAGE
					: mobt_pkg::WIN_LO_PAGE;
			end
			// hold off the lock pattern until the lock phase
			if (!allow_lock && it.address[1:0] == 2'd3 && it.data_value[7]
					&& !it.data_value[4]) begin
				it.data_value[4] = 1'b1;
			end
		end else if (pick < 60) begin
			it.action = mobt_pkg::ACT_PRG;
			if ($urandom_range(3) == 0) begin
				it.data_value[7:1] = 7'h7F;
			end
		end else if (pick < 95) begin
			it.action = mobt_pkg::ACT_CHR;
			case ($urandom_range(2))
				0: begin
					it.address = {4'h0, 2'($urandom_range(3)), 10'h000}
						^ {3'b000, it.inner_mode_bits[7], 12'h000};
				end
				1: begin
					it.address[15:13] = 3'b000;
				end
				default: begin
				end
			endcase
		end else begin
			it.action = ACT_NONE;
		end
		return it;
	endfunction

	task automatic send_txn(input mobt_pkg::in_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		if (it.action == mobt_pkg::ACT_PRG) begin
			prg_count++;
		end else if (it.action == mobt_pkg::ACT_CHR) begin
			chr_count++;
		end
		bank_results_q.push_back(translate_item(it));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (bank_results_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_window(input logic sel);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= sel;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		win_sel_m = sel;
	endtask

	task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct,
			input bit allow_lock);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_txn(random_item(allow_lock));
	endtask

	task automatic test_directed();
		set_window(1'b0);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_txn(mk_item(mobt_pkg::ACT_PRG, 16'h0000, 8'h00));
		send_txn(mk_item(mobt_pkg::ACT_PRG, 16'hFFFF, 8'hFF, 8'hFF));
		send_txn(mk_item(mobt_pkg::ACT_CHR, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_txn(mk_item(mobt_pkg::ACT_WRITE, 16'h5000, 8'hFF));
		send_txn(mk_item(mobt_pkg::ACT_WRITE, 16'h7000, 8'hFF));
		send_txn(mk_item(mobt_pkg::ACT_WRITE, 16'h6000, 8'h47));
		send_txn(mk_item(mobt_pkg::ACT_WRITE, 16'h6FFD, 8'hB6));
		send_txn(mk_item(mobt_pkg::ACT_WRITE, 16'h6002, 8'h0F));
		send_txn(mk_item(mobt_pkg::ACT_WRITE, 16'h6003, 8'h40));
		send_txn(mk_item(mobt_pkg::ACT_PRG, 16'hC000, 8'hFE, 8'h00));
		send_txn(mk_item(mobt_pkg::ACT_PRG, 16'hE000, 8'hFF, 8'h40));
		send_txn(mk_item(mobt_pkg::ACT_PRG, 16'hFFFF, 8'hFF, 8'h00));
		send_txn(mk_item(mobt_pkg::ACT_CHR, 16'h0000, 8'h11, 8'h00, 8'h5A, 8'hA5));
		send_txn(mk_item(mobt_pkg::ACT_CHR, 16'h1800, 8'h11, 8'h80, 8'h5A, 8'hA5));
		send_txn(mk_item(mobt_pkg::ACT_CHR, 16'h1400, 8'hFF, 8'h80, 8'h5A, 8'hA5));
		send_txn(mk_item(mobt_pkg::ACT_CHR, 16'h0C01, 8'hFF, 8'h00, 8'h5A, 8'hA5));
		send_txn(mk_item(ACT_NONE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_txn(mk_item(mobt_pkg::ACT_WRITE, 16'h6003, 8'h5E));
		send_txn(mk_item(mobt_pkg::ACT_PRG, 16'hA000, 8'h33));
		send_txn(mk_item(mobt_pkg::ACT_WRITE, 16'h6001, 8'h22));
		send_txn(mk_item(mobt_pkg::ACT_PRG, 16'h6000, 8'hFE));
		send_txn(mk_item(mobt_pkg::ACT_CHR, 16'h0C00, 8'hFF));
		send_txn(mk_item(mobt_pkg::ACT_CHR, 16'h1FFF, 8'h80));
	endtask

	task automatic test_idle_phases();
		int send_idle_mix[4];
		int recv_stall_mix[4];
		send_idle_mix = '{0, 69, 0, 37};
		recv_stall_mix = '{0, 0, 69, 37};
		for (int p = 0; p < 4; p++) begin
			for (int w = 0; w < 2; w++) begin
				set_window(w[0]);
				run_random_phase(225, send_idle_mix[p], recv_stall_mix[p], 1'b0);
			end
		end
	endtask

	task automatic test_lock();
		set_window(1'b1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_txn(mk_item(mobt_pkg::ACT_WRITE, 16'h5003, 8'h80));
		send_txn(mk_item(mobt_pkg::ACT_WRITE, 16'h5000, 8'hFF));
		send_txn(mk_item(mobt_pkg::ACT_WRITE, 16'h5FFF, 8'h00));
		run_random_phase(125, 37, 37, 1'b1);
	endtask

	always @(negedge clk) begin : check_results
		mobt_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (out_data.write_taken) begin
				taken_count++;
			end
			if (bank_results_q.size() == 0) begin
				$error("unexpected transaction: final_bank %0d window_slot %0d %s %0d",
					out_data.final_bank, out_data.window_slot, "write_taken",
					out_data.write_taken);
				mismatch_count++;
			end else begin
				want = bank_results_q.pop_front();
				checked_count++;
				if (out_data.final_bank !== want.final_bank) begin
					$error("final_bank: expected %0d, got %0d", want.final_bank,
						out_data.final_bank);
					mismatch_count++;
				end
				if (out_data.window_slot !== want.window_slot) begin
					$error("window_slot: expected %0d, got %0d", want.window_slot,
						out_data.window_slot);
					mismatch_count++;
				end
				if (out_data.write_taken !== want.write_taken) begin
					$error("write_taken: expected %0d, got %0d", want.write_taken,
						out_data.write_taken);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transaction in %0d cycles", QUIET_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_idle_phases();
		test_lock();
		drain_results();
		repeat (4) @(posedge clk);
		$display("covered %0d PRG and %0d CHR translations and %0d taken register writes",
			prg_count, chr_count, taken_count);
		$display("across both windows, four idle mixes and the locked state; %0d %s %0d %s",
			checked_count, "results,", mismatch_count, "mismatches");
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* multicart_outer_bank_translator_unit.f */
hdl/mobt_pkg.sv
hdl/mobt_regs.sv
hdl/mobt_xlate.sv
hdl/multicart_outer_bank_translator_unit.sv
test/tb_multicart_outer_bank_translator_unit.sv
